@@ rtl/telnet_iac_filter_responder_unit_macros.svh @@
// Assertion macros for the telnet IAC filter. Each macro expects signals named
// clk and rst_n in the scope where it is used.
`ifndef TELNET_IAC_FILTER_RESPONDER_UNIT_MACROS_SVH
`define TELNET_IAC_FILTER_RESPONDER_UNIT_MACROS_SVH

`ifndef SYNTH

`define TIFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TIFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TIFR_ASSERT_SAME(lbl, ante, cons, msg)
`define TIFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/tifr_pkg.sv @@
`default_nettype none

package tifr_pkg;

    localparam logic [7:0] IAC  = 8'd255;
    localparam logic [7:0] DONT = 8'd254;
    localparam logic [7:0] DO   = 8'd253;
    localparam logic [7:0] WONT = 8'd252;
    localparam logic [7:0] WILL = 8'd251;

    localparam logic [7:0] OPT_BINARY      = 8'd0;
    localparam logic [7:0] OPT_ECHO        = 8'd1;
    localparam logic [7:0] OPT_SUPPRESS_GA = 8'd3;
    localparam logic [7:0] OPT_TIMING_MARK = 8'd6;
    localparam logic [7:0] OPT_TERM_TYPE   = 8'd24;
    localparam logic [7:0] OPT_WINDOW_SIZE = 8'd31;
    localparam logic [7:0] OPT_TERM_SPEED  = 8'd32;
    localparam logic [7:0] OPT_REMOTE_FLOW = 8'd33;
    localparam logic [7:0] OPT_X_DISPLAY   = 8'd35;
    localparam logic [7:0] OPT_NEW_ENV     = 8'd39;

    // Word positions within a three-word reply.
    localparam logic [1:0] REPLY_POS_IAC = 2'd0;
    localparam logic [1:0] REPLY_POS_CMD = 2'd1;
    localparam logic [1:0] REPLY_POS_OPT = 2'd2;

    typedef enum logic [2:0] {
        ST_PLAIN     = 3'b001,
        ST_AFTER_IAC = 3'b010,
        ST_OPTION    = 3'b100
    } parse_state_t;

    // What one received byte produces: nothing, one data word, or a reply.
    typedef struct packed {
        logic       vld;
        logic       reply;
        logic [7:0] cmd;
        logic [7:0] data;
    } burst_t;

    // Answer to a DO for the given option; zero means no answer.
    function automatic logic [7:0] reply_for_do(input logic [7:0] opt);
        logic [7:0] r;
        case (opt)
            OPT_SUPPRESS_GA, OPT_TIMING_MARK: r = WILL;
            OPT_TERM_TYPE, OPT_WINDOW_SIZE, OPT_NEW_ENV, OPT_X_DISPLAY,
            OPT_TERM_SPEED, OPT_ECHO, OPT_REMOTE_FLOW, OPT_BINARY: r = WONT;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tifr_rx_if.sv @@
`default_nettype none

interface tifr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/tifr_res_if.sv @@
`default_nettype none

interface tifr_res_if;
    logic       valid;
    logic       ready;
    logic       dest;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output dest, output out_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input dest, input out_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/telnet_iac_filter_responder_unit.sv @@
// Telnet IAC filter and option responder.
// The rx channel takes one received byte per word. The res channel gives
// words tagged with dest: 0 for a byte to the device stream, 1 for a byte
// of a negotiation reply to the peer; last_of_run marks the final word
// caused by one received byte.
// A received byte that produces output shows its first word on res in the
// cycle after it is accepted. Plain bytes and escaped IAC IAC give one word
// and keep the rate at one byte per cycle while res.ready is high. A DO that
// draws an answer gives three words (IAC, WILL or WONT, option), which
// occupy the output register in turn; rx is held off until the last leaves.
// Bytes that produce nothing leave no word in the output register. A new byte
// is taken in the cycle the last word of the previous result leaves, so a
// single output register carries the flow.
// When res.ready is low, the pending word holds and rx stalls once the
// output register is full. Reset clears the parser to plain data state, the
// stored command to zero and empties the output register.
`default_nettype none

`include "telnet_iac_filter_responder_unit_macros.svh"

module telnet_iac_filter_responder_unit
    import tifr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tifr_rx_if.sink    rx,
    tifr_res_if.source res
);

    burst_t     burst;
    logic       acc;
    logic       last;
    logic       vld_reg;
    logic       reply_reg;
    logic [7:0] cmd_reg;
    logic [7:0] data_reg;
    logic [1:0] pos_reg;

    assign last     = !reply_reg || pos_reg == REPLY_POS_OPT;
    assign rx.ready = !vld_reg || (res.ready && last);
    assign acc      = rx.valid && rx.ready;

    tifr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .rx_byte (rx.rx_byte),
        .burst   (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            pos_reg <= REPLY_POS_IAC;
        end
        else if (acc)
        begin
            vld_reg <= burst.vld;
            pos_reg <= REPLY_POS_IAC;
        end
        else if (vld_reg && res.ready)
        begin
            if (last)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            reply_reg <= burst.reply;
            cmd_reg   <= burst.cmd;
            data_reg  <= burst.data;
        end
    end

    always_comb
    begin
        case (pos_reg)
            REPLY_POS_IAC: res.out_byte = reply_reg ? IAC : data_reg;
            REPLY_POS_CMD: res.out_byte = cmd_reg;
            default:       res.out_byte = data_reg;
        endcase
    end

    assign res.valid       = vld_reg;
    assign res.dest        = reply_reg;
    assign res.last_of_run = last;

    `TIFR_ASSERT_SAME(a_data_single_word, vld_reg && !reply_reg,
                      pos_reg == REPLY_POS_IAC, "data word off first position")
    `TIFR_ASSERT_SAME(a_partial_is_reply, res.valid && !res.last_of_run,
                      res.dest, "non-final word on device stream")
    `TIFR_ASSERT_NEXT(a_reply_continues, res.valid && res.ready && !res.last_of_run,
                      res.valid && res.dest, "reply run broken off")
    `TIFR_ASSERT_SAME(a_pos_in_range, vld_reg, pos_reg != 2'd3,
                      "reply position out of range")

endmodule

`default_nettype wire

@@ rtl/tifr_parser.sv @@
`default_nettype none

`include "telnet_iac_filter_responder_unit_macros.svh"

module tifr_parser
    import tifr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       acc,
    input  wire logic [7:0] rx_byte,
    output burst_t          burst
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic [7:0]   cmd_reg;
    logic [7:0]   cmd_next;
    logic [7:0]   do_reply;

    assign do_reply = reply_for_do(rx_byte);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        burst      = '0;
        burst.data = rx_byte;
        burst.cmd  = do_reply;
        unique case (state_reg)
            ST_AFTER_IAC:
            begin
                if (rx_byte == IAC)
                begin
                    burst.vld  = 1'b1;
                    state_next = ST_PLAIN;
                end
                else if (rx_byte == DO || rx_byte == DONT ||
                         rx_byte == WILL || rx_byte == WONT)
                begin
                    cmd_next   = rx_byte;
                    state_next = ST_OPTION;
                end
                else
                begin
                    state_next = ST_PLAIN;
                end
            end
            ST_OPTION:
            begin
                if (cmd_reg == DO && do_reply != 8'd0)
                begin
                    burst.vld   = 1'b1;
                    burst.reply = 1'b1;
                end
                state_next = ST_PLAIN;
            end
            default:
            begin
                // Plain data; a stray state code is handled the same way.
                if (rx_byte == IAC)
                begin
                    state_next = ST_AFTER_IAC;
                end
                else
                begin
                    burst.vld  = 1'b1;
                    state_next = ST_PLAIN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PLAIN;
            cmd_reg   <= 8'd0;
        end
        else if (acc)
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    `TIFR_ASSERT_NEXT(a_option_returns_plain, acc && state_reg == ST_OPTION,
                      state_reg == ST_PLAIN, "parser did not leave option state")
    `TIFR_ASSERT_SAME(a_reply_needs_do, burst.reply,
                      state_reg == ST_OPTION && cmd_reg == DO,
                      "reply produced outside a DO option")

endmodule

`default_nettype wire
